// ===== sv/mac_to_ip_binding_table_assert.svh =====
// assertion macros shared by the checker
`ifndef MAC_TO_IP_BINDING_TABLE_ASSERT_SVH
`define MAC_TO_IP_BINDING_TABLE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define MTIB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("binding table check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define MTIB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("binding table check failed");

`endif

// ===== sv/mtib_pkg.sv =====
package mtib_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;

    localparam logic CMD_NOTE   = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// ===== sv/mac_to_ip_binding_table.sv =====
// mac to ip binding table, fully associative, scanned one entry a cycle
// flow: one word at a time; input is ready only in idle, so the next word waits for the
//   scan and the finish step of the last one, and longer while a lookup result stalls
// lookup result: registered in the finish step after the scan; an empty table skips the scan
// reset: synchronous, active low; empties the table at once (fill count to
//   zero) and drops any pending result, no clearing pass is needed
module mac_to_ip_binding_table #(
    parameter int ENTRIES = mtib_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input side
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [79:0]                i_s_axis_tdata,   // mac[47:0], ip[79:48]
    input  logic [0:0]                 i_s_axis_tuser,   // command[0]
    // result side
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [31:0]                o_m_axis_tdata,   // client_ip[31:0]
    output logic [0:0]                 o_m_axis_tuser    // found[0]
);

    // index width for the memories, count width can also hold ENTRIES itself
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    localparam int MW = mtib_pkg::MAC_W;
    localparam int PW = mtib_pkg::IP_W;

    // entry storage, one read port with registered data
    logic [MW-1:0] mem_mac [ENTRIES];
    logic [PW-1:0] mem_ip  [ENTRIES];
    logic [MW-1:0] r_rd_mac;
    logic [PW-1:0] r_rd_ip;

    // control state
    mtib_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;     // entries are filled in order, so valid = below count
    logic [CW-1:0]    r_rd_cnt, n_rd_cnt;   // next entry to read
    logic             r_cmp_vld, n_cmp_vld; // read data of r_cmp_idx is due this cycle
    logic [IW-1:0]    r_cmp_idx, n_cmp_idx;
    logic             r_hit, n_hit;
    logic [IW-1:0]    r_hit_idx, n_hit_idx;
    logic [PW-1:0]    r_hit_ip, n_hit_ip;

    // the word under work
    logic             r_cmd, n_cmd;
    logic [MW-1:0]    r_key, n_key;
    logic [PW-1:0]    r_ip, n_ip;

    // output register
    logic             r_out_vld, n_out_vld;
    logic [PW-1:0]    r_out_ip, n_out_ip;
    logic             r_out_found, n_out_found;

    // combinational controls
    logic             s_accept;
    logic             rd_issue;
    logic             cmp_match;
    logic             cmp_last;
    logic             out_free;
    logic             we_mac;
    logic             we_ip;
    logic [IW-1:0]    wr_addr;

    assign s_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign rd_issue  = (r_state == mtib_pkg::ST_SCAN) && (r_rd_cnt < r_count);
    assign cmp_match = r_cmp_vld && (r_rd_mac == r_key);
    assign cmp_last  = r_cmp_vld && (CW'(r_cmp_idx) == (r_count - CW'(1)));
    assign out_free  = !r_out_vld || i_m_axis_tready;

    // next state and register values
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_cnt    = r_rd_cnt;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_ip    = r_hit_ip;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_ip        = r_ip;
        n_out_vld   = r_out_vld && !i_m_axis_tready;
        n_out_ip    = r_out_ip;
        n_out_found = r_out_found;

        case (r_state)
            mtib_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_cmd    = i_s_axis_tuser[0];
                    n_key    = i_s_axis_tdata[MW-1:0];
                    n_ip     = i_s_axis_tdata[MW+PW-1:MW];
                    n_rd_cnt = '0;
                    n_hit    = 1'b0;
                    // empty table: nothing to scan
                    n_state  = (r_count == '0) ? mtib_pkg::ST_FINISH : mtib_pkg::ST_SCAN;
                end
            end
            mtib_pkg::ST_SCAN: begin
                if (rd_issue) begin
                    n_rd_cnt  = r_rd_cnt + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_cnt[IW-1:0];
                end
                // first match in slot order wins
                if (cmp_match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_cmp_idx;
                    n_hit_ip  = r_rd_ip;
                    n_cmp_vld = 1'b0;
                    n_state   = mtib_pkg::ST_FINISH;
                end else if (cmp_last) begin
                    n_cmp_vld = 1'b0;
                    n_state   = mtib_pkg::ST_FINISH;
                end
            end
            mtib_pkg::ST_FINISH: begin
                if (r_cmd == mtib_pkg::CMD_NOTE) begin
                    // new binding takes the lowest free slot, dropped when full
                    if (!r_hit && (r_count != FULL)) begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = mtib_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_ip    = r_hit ? r_hit_ip : '0;
                    n_out_found = r_hit;
                    n_state     = mtib_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtib_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake and memory write controls
    always_comb begin
        o_s_axis_tready = (r_state == mtib_pkg::ST_IDLE);
        we_mac          = 1'b0;
        we_ip           = 1'b0;
        wr_addr         = r_hit ? r_hit_idx : r_count[IW-1:0];
        case (r_state)
            mtib_pkg::ST_FINISH: begin
                if (r_cmd == mtib_pkg::CMD_NOTE) begin
                    if (r_hit) begin
                        we_ip = 1'b1;
                    end else if (r_count != FULL) begin
                        we_mac = 1'b1;
                        we_ip  = 1'b1;
                    end
                end
            end
            default: begin
                we_mac = 1'b0;
            end
        endcase
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_out_ip;
    assign o_m_axis_tuser[0] = r_out_found;

    // entry memories: read at the read counter every cycle, used only during a scan; writes only in the finish step
    always_ff @(posedge i_clk) begin
        if (we_mac) begin
            mem_mac[wr_addr] <= r_key;
        end
        if (we_ip) begin
            mem_ip[wr_addr] <= r_ip;
        end
        r_rd_mac <= mem_mac[r_rd_cnt[IW-1:0]];
        r_rd_ip  <= mem_ip[r_rd_cnt[IW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mtib_pkg::ST_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_cnt    <= n_rd_cnt;
        r_cmp_idx   <= n_cmp_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_ip    <= n_hit_ip;
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_ip        <= n_ip;
        r_out_ip    <= n_out_ip;
        r_out_found <= n_out_found;
    end

endmodule

// ===== sv/mtib_checker.sv =====
`include "mac_to_ip_binding_table_assert.svh"

module mtib_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    logic s_take;
    logic m_stall;

    assign s_take  = i_s_axis_tvalid && o_s_axis_tready;
    assign m_stall = o_m_axis_tvalid && !i_m_axis_tready;

    // a stalled result word holds
    `MTIB_ASSERT_NEXT(a_out_hold, m_stall, o_m_axis_tvalid && $stable({o_m_axis_tdata, o_m_axis_tuser}))

    // a miss reports address zero
    `MTIB_ASSERT_NOW(a_miss_zero, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata == 32'd0)

    // one word at a time: input closes after a word is taken
    `MTIB_ASSERT_NEXT(a_one_at_a_time, s_take, !o_s_axis_tready)

    // a result never appears in the cycle right after a word is taken
    `MTIB_ASSERT_NEXT(a_no_instant_result, s_take, !$rose(o_m_axis_tvalid))

endmodule

bind mac_to_ip_binding_table mtib_checker u_mtib_checker (.*);
